// ----- src/rcp_pkg.sv -----
// shared types and constants of the 64-bit reciprocal unit
package rcp_pkg;

   localparam int unsigned DATA_W         = 64;
   localparam int unsigned SHIFT_W        = 6;
   localparam int unsigned SEED_W         = 11;
   localparam int unsigned SEED_ENTRIES   = 256;
   localparam int unsigned SEED_BASE      = 256;
   localparam int unsigned SEED_NUMERATOR = 523520;
   localparam logic [DATA_W-1:0] NEWTON_CONST = 64'h1000_0000_0000_0000;

   localparam int unsigned FRONT_STAGES = 2;
   localparam int unsigned FRONT_CNT_W  = $clog2(FRONT_STAGES + 1);
   localparam int unsigned QUEUE_DEPTH  = 4;
   localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);
   localparam int unsigned BACK_STAGES  = 18;
   // accept edge to the edge that ends the strobe cycle
   localparam int unsigned RSP_LATENCY  = 23;

   typedef struct packed {
      logic [DATA_W-1:0]  d;
      logic [SHIFT_W-1:0] sh;
      logic               nz;
   } rcp_item_type;

   typedef struct packed {
      logic [QUEUE_AW:0] count;
      logic              full;
      logic              empty;
   } rcp_qstat_type;

endpackage

// ----- src/reciprocal_64bit_divisor.sv -----
// top level of the 64-bit divisor reciprocal unit
//
// Usage: drive req_divisor and raise start; the transaction is taken at a
// rising clock edge where start is high and busy is low. A new divisor may
// be taken in every cycle, so the sustained rate is one transaction per
// clock. Each transaction yields one result, shown for exactly one cycle
// with rsp_strobe high: the normalized divisor, the reciprocal
// floor((2^128-1)/d) - 2^64, the leading-zero count and valid_res. A zero
// divisor gives all-zero fields with valid_res low.
// From the accepting edge, a transaction passes two front stages that
// count leading zeros and shift, the queue write and one registered queue
// read, then 18 arithmetic stages where every 64x64 product is cut into
// 32x32 partial products summed over the following stages, and one output
// register.
// Results cannot be held off by the receiver; the arithmetic pipeline
// drains the queue every cycle, so busy stays low except during reset.
// Reset is synchronous and empties the front stages, the queue and the
// pipeline; transactions in flight are dropped.
module reciprocal_64bit_divisor import rcp_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [DATA_W-1:0]  req_divisor,
   output logic               rsp_strobe,
   output logic [DATA_W-1:0]  rsp_normalized_divisor,
   output logic [DATA_W-1:0]  rsp_reciprocal,
   output logic [SHIFT_W-1:0] rsp_shift_count,
   output logic               rsp_valid_res
);

   logic                   accept;
   rcp_item_type           front_item;
   logic                   front_vld;
   logic [FRONT_CNT_W-1:0] inflight;
   rcp_item_type           head_item;
   logic                   head_vld;
   rcp_qstat_type          qstat;
   logic [QUEUE_AW+1:0]    occupancy;

   // credit check: queue entries plus transactions still in the front stages
   assign occupancy = (QUEUE_AW+2)'(qstat.count) + (QUEUE_AW+2)'(inflight);
   assign busy      = reset || (occupancy >= (QUEUE_AW+2)'(QUEUE_DEPTH));
   assign accept    = start && !busy;

   rcp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .divisor  (req_divisor),
      .item     (front_item),
      .item_vld (front_vld),
      .inflight (inflight)
   );

   rcp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_vld),
      .push_item (front_item),
      .head_item (head_item),
      .head_vld  (head_vld),
      .qstat     (qstat)
   );

   rcp_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .head_item              (head_item),
      .head_vld               (head_vld),
      .rsp_strobe             (rsp_strobe),
      .rsp_normalized_divisor (rsp_normalized_divisor),
      .rsp_reciprocal         (rsp_reciprocal),
      .rsp_shift_count        (rsp_shift_count),
      .rsp_valid_res          (rsp_valid_res)
   );

   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##RSP_LATENCY rsp_strobe)
      else $error("result strobe missing at the fixed latency");

   a_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !front_vld)
      else $error("front end pushed into a full queue");

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_valid_res) |->
         (rsp_normalized_divisor == '0 && rsp_reciprocal == '0 && rsp_shift_count == '0))
      else $error("zero divisor result not cleared");

   a_normalized: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_valid_res) |-> rsp_normalized_divisor[DATA_W-1])
      else $error("normalized divisor lacks its top bit");

endmodule

// ----- src/rcp_front.sv -----
// front end: leading-zero count and normalization over two stages
module rcp_front import rcp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [DATA_W-1:0]      divisor,
   output rcp_item_type           item,
   output logic                   item_vld,
   output logic [FRONT_CNT_W-1:0] inflight
);

   logic              f1_vld_ff, f1_vld_in;
   logic [DATA_W-1:0] f1_x_ff, f1_x_in;
   logic [2:0]        f1_n_ff, f1_n_in;
   logic              f1_nz_ff, f1_nz_in;
   logic              f2_vld_ff;
   rcp_item_type      f2_item_ff, f2_item_in;

   // coarse steps: 32, 16, 8
   always_comb begin
      f1_vld_in = accept;
      f1_nz_in  = |divisor;
      f1_x_in   = divisor;
      f1_n_in   = 3'd0;
      if (f1_x_in[63:32] == 32'd0) begin
         f1_n_in[2] = 1'b1;
         f1_x_in    = {f1_x_in[31:0], 32'd0};
      end
      if (f1_x_in[63:48] == 16'd0) begin
         f1_n_in[1] = 1'b1;
         f1_x_in    = {f1_x_in[47:0], 16'd0};
      end
      if (f1_x_in[63:56] == 8'd0) begin
         f1_n_in[0] = 1'b1;
         f1_x_in    = {f1_x_in[55:0], 8'd0};
      end
   end

   // fine steps: 4, 2, 1
   always_comb begin
      logic [DATA_W-1:0] y;
      logic [2:0]        m;
      y = f1_x_ff;
      m = 3'd0;
      if (y[63:60] == 4'd0) begin
         m[2] = 1'b1;
         y    = {y[59:0], 4'd0};
      end
      if (y[63:62] == 2'd0) begin
         m[1] = 1'b1;
         y    = {y[61:0], 2'd0};
      end
      if (!y[63]) begin
         m[0] = 1'b1;
         y    = {y[62:0], 1'b0};
      end
      f2_item_in.d  = y;
      f2_item_in.sh = f1_nz_ff ? {f1_n_ff, m} : '0;
      f2_item_in.nz = f1_nz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else begin
         f1_vld_ff <= f1_vld_in;
         f2_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      f1_x_ff    <= f1_x_in;
      f1_n_ff    <= f1_n_in;
      f1_nz_ff   <= f1_nz_in;
      f2_item_ff <= f2_item_in;
   end

   assign item     = f2_item_ff;
   assign item_vld = f2_vld_ff;
   assign inflight = FRONT_CNT_W'(f1_vld_ff) + FRONT_CNT_W'(f2_vld_ff);

endmodule

// ----- src/rcp_queue.sv -----
// short queue between front end and arithmetic pipeline
module rcp_queue import rcp_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  rcp_item_type  push_item,
   output rcp_item_type  head_item,
   output logic          head_vld,
   output rcp_qstat_type qstat
);

   rcp_item_type      mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                head_vld_ff;
   rcp_item_type        head_item_ff;
   logic                pop;

   // back end never stalls, so drain whenever something is held
   assign pop = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         head_vld_ff <= 1'b0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         head_vld_ff <= pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_item;
      end
      if (pop) begin
         head_item_ff <= mem[rd_ptr_ff];
      end
   end

   assign head_item   = head_item_ff;
   assign head_vld    = head_vld_ff;
   assign qstat.count = count_ff;
   assign qstat.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);

endmodule

// ----- src/rcp_back.sv -----
// arithmetic pipeline: seed lookup, three newton steps, final correction
module rcp_back import rcp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  rcp_item_type        head_item,
   input  logic                head_vld,
   output logic                rsp_strobe,
   output logic [DATA_W-1:0]   rsp_normalized_divisor,
   output logic [DATA_W-1:0]   rsp_reciprocal,
   output logic [SHIFT_W-1:0]  rsp_shift_count,
   output logic                rsp_valid_res
);

   // seed table, entry i = floor((2^19 - 3*2^8) / (256 + i))
   logic [SEED_W-1:0] seed_rom [SEED_ENTRIES];
   for (genvar gi = 0; gi < SEED_ENTRIES; gi++) begin : g_seed
      localparam int unsigned Denom = SEED_BASE + gi;
      assign seed_rom[gi] = SEED_W'(SEED_NUMERATOR / Denom);
   end

   // item and valid travel alongside the arithmetic
   rcp_item_type carry_ff [1:BACK_STAGES];
   rcp_item_type carry_in [1:BACK_STAGES];
   logic         vld_ff   [1:BACK_STAGES];
   logic         vld_in   [1:BACK_STAGES];

   logic [10:0] s1_v0_ff, s1_v0_in;
   logic [10:0] s2_v0_ff;
   logic [21:0] s2_sq_ff, s2_sq_in;
   logic [10:0] s3_v0_ff;
   logic [62:0] s3_m1_ff, s3_m1_in;
   logic [21:0] s4_v1_ff, s4_v1_in;
   logic [21:0] s5_v1_ff;
   logic [62:0] s5_m2_ff, s5_m2_in;
   logic [21:0] s6_v1_ff;
   logic [53:0] s6_ptl_ff, s6_ptl_in;
   logic [31:0] s6_pth_ff, s6_pth_in;
   logic [34:0] s7_v2_ff, s7_v2_in;
   logic [34:0] s8_v2_ff;
   logic [63:0] s8_q0_ff, s8_q0_in;
   logic [31:0] s8_q1_ff, s8_q1_in;
   logic [31:0] s8_q2_ff, s8_q2_in;
   logic [34:0] s9_v2_ff;
   logic [63:0] s9_dv_ff, s9_dv_in;
   logic [34:0] s10_v2_ff;
   logic [63:0] s10_e_ff, s10_e_in;
   logic [34:0] s11_v2_ff;
   logic [63:0] s11_r0_ff, s11_r0_in;
   logic [63:0] s11_r1_ff, s11_r1_in;
   logic [34:0] s11_r2_ff, s11_r2_in;
   logic [34:0] s11_r3_ff, s11_r3_in;
   logic [34:0] s12_v2_ff;
   logic [63:0] s12_r0_ff;
   logic [34:0] s12_r3_ff;
   logic [64:0] s12_rmid_ff, s12_rmid_in;
   logic [34:0] s13_v2_ff;
   logic [34:0] s13_r3_ff;
   logic [65:0] s13_s_ff, s13_s_in;
   logic [63:0] s14_v3_ff, s14_v3_in;
   logic [63:0] s15_v3_ff;
   logic [63:0] s15_u0_ff, s15_u0_in;
   logic [63:0] s15_u1_ff, s15_u1_in;
   logic [63:0] s15_u2_ff, s15_u2_in;
   logic [63:0] s15_u3_ff, s15_u3_in;
   logic [63:0] s16_v3_ff;
   logic [63:0] s16_u3_ff;
   logic [64:0] s16_umid_ff, s16_umid_in;
   logic [64:0] s16_w_ff, s16_w_in;
   logic [63:0] s17_v3_ff;
   logic [63:0] s17_u3_ff;
   logic [65:0] s17_s2_ff, s17_s2_in;
   logic [63:0] s18_v3_ff;
   logic [63:0] s18_ph_ff, s18_ph_in;

   logic                rsp_strobe_ff;
   logic [DATA_W-1:0]   rsp_norm_ff, rsp_norm_in;
   logic [DATA_W-1:0]   rsp_recip_ff, rsp_recip_in;
   logic [SHIFT_W-1:0]  rsp_shift_ff, rsp_shift_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_comb begin
      carry_in[1] = head_item;
      vld_in[1]   = head_vld;
      for (int k = 2; k <= BACK_STAGES; k++) begin
         carry_in[k] = carry_ff[k-1];
         vld_in[k]   = vld_ff[k-1];
      end
   end

   always_comb begin
      logic [40:0] d40_a;
      logic [40:0] d40_b;
      logic [63:0] t;
      logic [63:0] prod;
      logic [63:0] d63;
      logic [63:0] half;
      logic [35:0] mh;
      logic [63:0] dd;

      // seed from bits 62..55
      s1_v0_in = seed_rom[head_item.d[62:55]];

      s2_sq_in = s1_v0_ff * s1_v0_ff;

      d40_a    = {1'b0, carry_ff[2].d[63:24]} + 41'd1;
      s3_m1_in = d40_a * s2_sq_ff;

      s4_v1_in = 22'({s3_v0_ff, 11'd0} - s3_m1_ff[62:40] - 23'd1);

      d40_b    = {1'b0, carry_ff[4].d[63:24]} + 41'd1;
      s5_m2_in = d40_b * s4_v1_ff;

      t         = NEWTON_CONST - {1'b0, s5_m2_ff};
      s6_ptl_in = t[31:0] * s5_v1_ff;
      s6_pth_in = 32'(t[63:32] * s5_v1_ff);

      prod     = {10'd0, s6_ptl_ff} + {s6_pth_ff, 32'd0};
      s7_v2_in = {s6_v1_ff, 13'd0} + {18'd0, prod[63:47]};

      // low half of d63 * v2
      d63      = {1'b0, carry_ff[7].d[63:1]} + {63'd0, carry_ff[7].d[0]};
      s8_q0_in = d63[31:0] * s7_v2_ff[31:0];
      s8_q1_in = 32'(d63[63:32] * s7_v2_ff[31:0]);
      s8_q2_in = 32'(d63[31:0] * s7_v2_ff[34:32]);

      s9_dv_in = s8_q0_ff + {s8_q1_ff + s8_q2_ff, 32'd0};

      half     = {30'd0, s9_v2_ff[34:1]};
      s10_e_in = (carry_ff[9].d[0] ? half : 64'd0) - s9_dv_ff;

      // partial products of v2 * e
      s11_r0_in = s10_v2_ff[31:0] * s10_e_ff[31:0];
      s11_r1_in = s10_v2_ff[31:0] * s10_e_ff[63:32];
      s11_r2_in = s10_v2_ff[34:32] * s10_e_ff[31:0];
      s11_r3_in = s10_v2_ff[34:32] * s10_e_ff[63:32];

      s12_rmid_in = {1'b0, s11_r1_ff} + {30'd0, s11_r2_ff};

      s13_s_in = {1'b0, s12_rmid_ff} + {34'd0, s12_r0_ff[63:32]};

      mh        = {1'b0, s13_r3_ff} + {2'd0, s13_s_ff[65:32]};
      s14_v3_in = {s13_v2_ff[32:0], 31'd0} + {29'd0, mh[35:1]};

      // partial products of v3 * d
      dd        = carry_ff[14].d;
      s15_u0_in = s14_v3_ff[31:0] * dd[31:0];
      s15_u1_in = s14_v3_ff[31:0] * dd[63:32];
      s15_u2_in = s14_v3_ff[63:32] * dd[31:0];
      s15_u3_in = s14_v3_ff[63:32] * dd[63:32];

      // the extra d of v3*d + d folds into the low partial
      s16_umid_in = {1'b0, s15_u1_ff} + {1'b0, s15_u2_ff};
      s16_w_in    = {1'b0, s15_u0_ff} + {1'b0, carry_ff[15].d};

      s17_s2_in = {1'b0, s16_umid_ff} + {33'd0, s16_w_ff[64:32]};

      s18_ph_in = s17_u3_ff + {30'd0, s17_s2_ff[65:32]};

      rsp_valid_in = carry_ff[18].nz;
      rsp_norm_in  = carry_ff[18].nz ? carry_ff[18].d : '0;
      rsp_shift_in = carry_ff[18].nz ? carry_ff[18].sh : '0;
      rsp_recip_in = carry_ff[18].nz ? (s18_v3_ff - s18_ph_ff - carry_ff[18].d) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= BACK_STAGES; k++) begin
            vld_ff[k] <= 1'b0;
         end
         rsp_strobe_ff <= 1'b0;
      end else begin
         for (int k = 1; k <= BACK_STAGES; k++) begin
            vld_ff[k] <= vld_in[k];
         end
         rsp_strobe_ff <= vld_ff[BACK_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= BACK_STAGES; k++) begin
         carry_ff[k] <= carry_in[k];
      end
      s1_v0_ff    <= s1_v0_in;
      s2_v0_ff    <= s1_v0_ff;
      s2_sq_ff    <= s2_sq_in;
      s3_v0_ff    <= s2_v0_ff;
      s3_m1_ff    <= s3_m1_in;
      s4_v1_ff    <= s4_v1_in;
      s5_v1_ff    <= s4_v1_ff;
      s5_m2_ff    <= s5_m2_in;
      s6_v1_ff    <= s5_v1_ff;
      s6_ptl_ff   <= s6_ptl_in;
      s6_pth_ff   <= s6_pth_in;
      s7_v2_ff    <= s7_v2_in;
      s8_v2_ff    <= s7_v2_ff;
      s8_q0_ff    <= s8_q0_in;
      s8_q1_ff    <= s8_q1_in;
      s8_q2_ff    <= s8_q2_in;
      s9_v2_ff    <= s8_v2_ff;
      s9_dv_ff    <= s9_dv_in;
      s10_v2_ff   <= s9_v2_ff;
      s10_e_ff    <= s10_e_in;
      s11_v2_ff   <= s10_v2_ff;
      s11_r0_ff   <= s11_r0_in;
      s11_r1_ff   <= s11_r1_in;
      s11_r2_ff   <= s11_r2_in;
      s11_r3_ff   <= s11_r3_in;
      s12_v2_ff   <= s11_v2_ff;
      s12_r0_ff   <= s11_r0_ff;
      s12_r3_ff   <= s11_r3_ff;
      s12_rmid_ff <= s12_rmid_in;
      s13_v2_ff   <= s12_v2_ff;
      s13_r3_ff   <= s12_r3_ff;
      s13_s_ff    <= s13_s_in;
      s14_v3_ff   <= s14_v3_in;
      s15_v3_ff   <= s14_v3_ff;
      s15_u0_ff   <= s15_u0_in;
      s15_u1_ff   <= s15_u1_in;
      s15_u2_ff   <= s15_u2_in;
      s15_u3_ff   <= s15_u3_in;
      s16_v3_ff   <= s15_v3_ff;
      s16_u3_ff   <= s15_u3_ff;
      s16_umid_ff <= s16_umid_in;
      s16_w_ff    <= s16_w_in;
      s17_v3_ff   <= s16_v3_ff;
      s17_u3_ff   <= s16_u3_ff;
      s17_s2_ff   <= s17_s2_in;
      s18_v3_ff   <= s17_v3_ff;
      s18_ph_ff   <= s18_ph_in;
      rsp_norm_ff  <= rsp_norm_in;
      rsp_recip_ff <= rsp_recip_in;
      rsp_shift_ff <= rsp_shift_in;
      rsp_valid_ff <= rsp_valid_in;
   end

   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_normalized_divisor = rsp_norm_ff;
   assign rsp_reciprocal         = rsp_recip_ff;
   assign rsp_shift_count        = rsp_shift_ff;
   assign rsp_valid_res          = rsp_valid_ff;

endmodule

// ----- verif/tb.sv -----
// self-checking testbench of the 64-bit divisor reciprocal unit
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rcp_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1350;
   localparam int unsigned STALL_LIMIT  = 1000;

   typedef struct packed {
      logic [DATA_W-1:0]  norm;
      logic [DATA_W-1:0]  recip;
      logic [SHIFT_W-1:0] shift;
      logic               nonzero;
   } recip_result_type;

   class recip_board_type;
      recip_result_type expected_q[$];
      int               errors;

      function new();
         errors = 0;
      endfunction

      static function logic [DATA_W-1:0] prod_hi(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
         logic [2*DATA_W-1:0] p;
         p = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
         return p[2*DATA_W-1:DATA_W];
      endfunction

      // normalize, table seed, three newton steps, final correction
      function recip_result_type predict_reciprocal(logic [DATA_W-1:0] a);
         logic [DATA_W-1:0] d, d40, d63, mask, v0, v1, v2, v3, v4, e, t, lo, lo2, hi;
         int unsigned       sh;
         recip_result_type  r;
         r = '0;
         if (a == '0) return r;
         d = a;
         sh = 0;
         while (!d[DATA_W-1]) begin
            d = d << 1;
            sh++;
         end
         d40 = (d >> 24) + 64'd1;
         d63 = (d >> 1) + {63'd0, d[0]};
         mask = {DATA_W{d[0]}};
         v0 = 64'(SEED_NUMERATOR / (SEED_BASE + d[62:55]));
         t = d40 * (v0 * v0);
         v1 = (v0 << 11) - (t >> 40) - 64'd1;
         t = (NEWTON_CONST - d40 * v1) * v1;
         v2 = (v1 << 13) + (t >> 47);
         e = ((v2 >> 1) & mask) - d63 * v2;
         v3 = (v2 << 31) + (prod_hi(v2, e) >> 1);
         lo = v3 * d;
         lo2 = lo + d;
         hi = prod_hi(v3, d) + ((lo2 < lo) ? 64'd1 : 64'd0);
         v4 = v3 - hi - d;
         r.norm = d;
         r.recip = v4;
         r.shift = sh[SHIFT_W-1:0];
         r.nonzero = 1'b1;
         return r;
      endfunction

      function void note_divisor(logic [DATA_W-1:0] a);
         expected_q.push_back(predict_reciprocal(a));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
         $display("tb: mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
         errors++;
      endtask

      task check_result(recip_result_type got);
         recip_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("result with no transaction", got.recip, '0);
            return;
         end
         want = expected_q.pop_front();
         if (got.norm !== want.norm)
            report_mismatch("normalized_divisor", got.norm, want.norm);
         if (got.recip !== want.recip)
            report_mismatch("reciprocal", got.recip, want.recip);
         if (got.shift !== want.shift)
            report_mismatch("shift_count", 64'(got.shift), 64'(want.shift));
         if (got.nonzero !== want.nonzero)
            report_mismatch("valid_res", 64'(got.nonzero), 64'(want.nonzero));
      endtask

      task flush_leftover();
         if (expected_q.size() != 0)
            report_mismatch("results never seen", 64'(expected_q.size()), '0);
      endtask
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [DATA_W-1:0]  req_divisor;
   logic               rsp_strobe;
   logic [DATA_W-1:0]  rsp_normalized_divisor;
   logic [DATA_W-1:0]  rsp_reciprocal;
   logic [SHIFT_W-1:0] rsp_shift_count;
   logic               rsp_valid_res;

   recip_board_type board;
   int unsigned     stall_cycles = 0;

   logic [DATA_W-1:0] directed_divisors[$] = '{
      64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h0000_0000_0000_0002,
      64'h0000_0000_0000_0003, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
      64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFF,
      64'hFF80_0000_0000_0000, 64'h807F_FFFF_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF,
      64'h0000_0001_0000_0000, 64'hC000_0000_0000_0000, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h5555_5555_5555_5555, 64'h0000_0000_0000_8000, 64'h0123_4567_89AB_CDEF,
      64'hFEDC_BA98_7654_3210, 64'h0000_0000_0000_0000, 64'h0000_0000_0000_0007
   };

   reciprocal_64bit_divisor dut (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_divisor            (req_divisor),
      .rsp_strobe             (rsp_strobe),
      .rsp_normalized_divisor (rsp_normalized_divisor),
      .rsp_reciprocal         (rsp_reciprocal),
      .rsp_shift_count        (rsp_shift_count),
      .rsp_valid_res          (rsp_valid_res)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // spread of leading-zero counts, sparse bit patterns and a few zeros
   function automatic logic [DATA_W-1:0] random_divisor();
      logic [DATA_W-1:0] r;
      r = {$urandom, $urandom};
      case ($urandom_range(19))
         0:       return '0;
         1:       return 64'd1 << $urandom_range(63);
         2:       return ~64'd0 >> $urandom_range(63);
         3:       return r << $urandom_range(63);
         default: return r >> $urandom_range(63);
      endcase
   endfunction

   task automatic idle_cycle();
      start <= 1'b0;
      req_divisor <= {$urandom, $urandom};
      @(posedge clock);
   endtask

   task automatic send_divisor(logic [DATA_W-1:0] value, bit may_idle);
      if (may_idle)
         while ($urandom_range(99) < 7) idle_cycle();
      start <= 1'b1;
      req_divisor <= value;
      do @(posedge clock); while (busy);
   endtask

   // accepted transactions in, results out
   always @(posedge clock) begin
      if (!reset && start && !busy)
         board.note_divisor(req_divisor);
      if (!reset && rsp_strobe)
         board.check_result('{rsp_normalized_divisor, rsp_reciprocal,
                              rsp_shift_count, rsp_valid_res});
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_divisor = '0;
      board = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_divisors[i]) send_divisor(directed_divisors[i], 1'b1);
      // a long run of back-to-back transactions in the middle
      for (int n = 0; n < RANDOM_ITEMS; n++)
         send_divisor(random_divisor(), !(n >= 400 && n < 700));
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (RSP_LATENCY + 4) @(posedge clock);
      board.flush_leftover();
      if (board.errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end

endmodule
